// File: hw/rtl/ccmt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccmt_pkg - shared types, constants and month table for the calendar clock
//
// Item and result structures, field limits and the month length lookup.
// ----------------------------------------------------------------------------
package ccmt_pkg;

   typedef enum logic {
      CMD_TICK = 1'b0,
      CMD_SET  = 1'b1
   } cmd_type;

   localparam logic [9:0]  MSEC_MAX    = 10'd999;
   localparam logic [5:0]  SEC_MAX     = 6'd59;
   localparam logic [5:0]  MIN_MAX     = 6'd59;
   localparam logic [4:0]  HOUR_MAX    = 5'd23;
   localparam logic [4:0]  DAY_FIRST   = 5'd1;
   localparam logic [3:0]  MONTH_FIRST = 4'd1;
   localparam logic [3:0]  MONTH_FEB   = 4'd2;
   localparam logic [3:0]  MONTH_MAX   = 4'd12;
   localparam logic [11:0] YEAR_BASE   = 12'd2000;
   localparam logic [11:0] YEAR_LAST   = 12'd2099;

   // Month lengths indexed by month number; unused codes read as zero.
   localparam logic [4:0] MONTH_LEN [16] = '{
      5'd0,  5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
      5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0,  5'd0,  5'd0
   };

   typedef struct packed {
      cmd_type     cmd;
      logic [9:0]  new_msec;
      logic [5:0]  new_sec;
      logic [5:0]  new_min;
      logic [4:0]  new_hour;
      logic [4:0]  new_day;
      logic [3:0]  new_month;
      logic [11:0] new_year;
   } ccmt_item_type;

   typedef struct packed {
      logic [9:0]  cur_msec;
      logic [5:0]  cur_sec;
      logic [5:0]  cur_min;
      logic [4:0]  cur_hour;
      logic [4:0]  cur_day;
      logic [3:0]  cur_month;
      logic [11:0] cur_year;
      logic        set_ok;
      logic [31:0] uptime_ms;
   } ccmt_rsp_type;

   // Days in a month; February gains a day when the year is a multiple of four.
   function automatic logic [4:0] month_days(input logic [3:0] month,
                                             input logic [1:0] year_low);
      logic [4:0] days;
      days = MONTH_LEN[month];
      if (month == MONTH_FEB && year_low == 2'b00) begin
         days = days + 5'd1;
      end
      return days;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/calendar_clock_ms_tick.sv
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_clock_ms_tick - millisecond calendar clock with uptime counter
//
// Request channel: tuser = 0 is a one-millisecond tick, tuser = 1 loads the
// time from tdata if every field is valid (years 2000 to 2099, real dates).
// Response channel: one transfer per request with the time after the step,
// the uptime count and, in tuser, whether a load was taken.
// Path: the request transfer loads the input register; the calendar update is
// then loaded into the result register, and the response is valid once it holds it.
// Throughput: one request per cycle while responses are taken, set by the
// combinational carry chain and load check in front of the result register.
// Reset: time 2000-01-01 00:00:00.000, uptime 0, both registers empty.
// Stall: a held response keeps its value; the input register takes one more
// request, then req_tready drops until the response transfer completes.
// ----------------------------------------------------------------------------
module calendar_clock_ms_tick (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // new_msec, new_sec, new_min, new_hour, new_day, new_month, new_year
   input  wire logic [47:0] req_tdata,
   // cmd
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // cur_msec, cur_sec, cur_min, cur_hour, cur_day, cur_month, cur_year, uptime_ms
   output logic [79:0]      rsp_tdata,
   // set_ok
   output logic             rsp_tuser
);
   import ccmt_pkg::*;

   logic          item_vld;
   logic          take;
   logic          step_en;
   ccmt_item_type item;
   ccmt_rsp_type  rsp;

   assign step_en = item_vld && take;

   ccmt_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (take),
      .item_vld   (item_vld),
      .item       (item)
   );

   ccmt_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (item),
      .rsp     (rsp)
   );

   ccmt_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_en),
      .rsp        (rsp),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

// File: hw/rtl/ccmt_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccmt_in_stage - input register of the calendar clock
//
// Captures one request transfer and unpacks it into an item structure.
// ----------------------------------------------------------------------------
module ccmt_in_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [47:0]            req_tdata,
   input  wire logic                   req_tuser,
   input  wire logic                   take,
   output logic                        item_vld,
   output ccmt_pkg::ccmt_item_type     item
);
   import ccmt_pkg::*;

   logic          item_vld_ff;
   logic          item_vld_in;
   ccmt_item_type item_ff;
   ccmt_item_type item_in;

   assign req_tready = !item_vld_ff || take;

   always_comb begin
      item_in.cmd       = cmd_type'(req_tuser);
      item_in.new_msec  = req_tdata[9:0];
      item_in.new_sec   = req_tdata[15:10];
      item_in.new_min   = req_tdata[21:16];
      item_in.new_hour  = req_tdata[26:22];
      item_in.new_day   = req_tdata[31:27];
      item_in.new_month = req_tdata[35:32];
      item_in.new_year  = req_tdata[47:36];
   end

   // Hold while the item is stalled, otherwise follow the request side.
   assign item_vld_in = req_tready ? req_tvalid : item_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
      end else begin
         item_vld_ff <= item_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
   end

   assign item_vld = item_vld_ff;
   assign item     = item_ff;

endmodule
`default_nettype wire

// File: hw/rtl/ccmt_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccmt_core - calendar state and combinational update
//
// Holds the calendar and uptime counters, applies a tick carry chain or a
// checked load, and presents the state after the step.
// ----------------------------------------------------------------------------
module ccmt_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step_en,
   input  wire ccmt_pkg::ccmt_item_type item,
   output ccmt_pkg::ccmt_rsp_type      rsp
);
   import ccmt_pkg::*;

   logic [9:0]  ms_ff,    ms_in;
   logic [5:0]  sec_ff,   sec_in;
   logic [5:0]  min_ff,   min_in;
   logic [4:0]  hour_ff,  hour_in;
   logic [4:0]  day_ff,   day_in;
   logic [3:0]  month_ff, month_in;
   logic [6:0]  year_ff,  year_in;
   logic [31:0] tick_ff,  tick_in;
   logic        set_valid;
   logic        set_ok;

   assign set_valid = (item.new_msec <= MSEC_MAX) && (item.new_sec <= SEC_MAX) &&
                      (item.new_min <= MIN_MAX) && (item.new_hour <= HOUR_MAX) &&
                      (item.new_day >= DAY_FIRST) && (item.new_month >= MONTH_FIRST) &&
                      (item.new_month <= MONTH_MAX) &&
                      (item.new_year >= YEAR_BASE) && (item.new_year <= YEAR_LAST) &&
                      (item.new_day <= month_days(item.new_month, item.new_year[1:0]));

   always_comb begin
      ms_in    = ms_ff;
      sec_in   = sec_ff;
      min_in   = min_ff;
      hour_in  = hour_ff;
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      tick_in  = tick_ff;
      set_ok   = 1'b0;
      unique case (item.cmd)
         CMD_TICK: begin
            tick_in = tick_ff + 32'd1;
            // Cascade the carry up through the calendar fields.
            if (ms_ff < MSEC_MAX) begin
               ms_in = ms_ff + 10'd1;
            end else begin
               ms_in = '0;
               if (sec_ff < SEC_MAX) begin
                  sec_in = sec_ff + 6'd1;
               end else begin
                  sec_in = '0;
                  if (min_ff < MIN_MAX) begin
                     min_in = min_ff + 6'd1;
                  end else begin
                     min_in = '0;
                     if (hour_ff < HOUR_MAX) begin
                        hour_in = hour_ff + 5'd1;
                     end else begin
                        hour_in = '0;
                        if (day_ff < month_days(month_ff, year_ff[1:0])) begin
                           day_in = day_ff + 5'd1;
                        end else begin
                           day_in = DAY_FIRST;
                           if (month_ff < MONTH_MAX) begin
                              month_in = month_ff + 4'd1;
                           end else begin
                              month_in = MONTH_FIRST;
                              year_in  = year_ff + 7'd1;
                           end
                        end
                     end
                  end
               end
            end
         end
         CMD_SET: begin
            if (set_valid) begin
               ms_in    = item.new_msec;
               sec_in   = item.new_sec;
               min_in   = item.new_min;
               hour_in  = item.new_hour;
               day_in   = item.new_day;
               month_in = item.new_month;
               year_in  = 7'(item.new_year - YEAR_BASE);
               set_ok   = 1'b1;
            end
         end
         default: begin
            set_ok = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ms_ff    <= '0;
         sec_ff   <= '0;
         min_ff   <= '0;
         hour_ff  <= '0;
         day_ff   <= DAY_FIRST;
         month_ff <= MONTH_FIRST;
         year_ff  <= '0;
         tick_ff  <= '0;
      end else if (step_en) begin
         ms_ff    <= ms_in;
         sec_ff   <= sec_in;
         min_ff   <= min_in;
         hour_ff  <= hour_in;
         day_ff   <= day_in;
         month_ff <= month_in;
         year_ff  <= year_in;
         tick_ff  <= tick_in;
      end
   end

   always_comb begin
      rsp.cur_msec  = ms_in;
      rsp.cur_sec   = sec_in;
      rsp.cur_min   = min_in;
      rsp.cur_hour  = hour_in;
      rsp.cur_day   = day_in;
      rsp.cur_month = month_in;
      rsp.cur_year  = YEAR_BASE + {5'd0, year_in};
      rsp.set_ok    = set_ok;
      rsp.uptime_ms = tick_in;
   end

   a_calendar_in_range: assert property (@(posedge clock) disable iff (reset)
      ms_ff <= MSEC_MAX && sec_ff <= SEC_MAX && min_ff <= MIN_MAX && hour_ff <= HOUR_MAX)
      else $error("time of day out of range");

   a_date_in_range: assert property (@(posedge clock) disable iff (reset)
      month_ff >= MONTH_FIRST && month_ff <= MONTH_MAX && day_ff >= DAY_FIRST &&
      day_ff <= month_days(month_ff, year_ff[1:0]))
      else $error("date out of range");

   a_tick_counts: assert property (@(posedge clock) disable iff (reset)
      step_en && item.cmd == CMD_TICK |=> tick_ff == $past(tick_ff) + 32'd1)
      else $error("uptime did not advance on tick");

   a_set_keeps_uptime: assert property (@(posedge clock) disable iff (reset)
      step_en && item.cmd == CMD_SET |=> $stable(tick_ff))
      else $error("uptime changed on set");

   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      step_en && item.cmd == CMD_SET && !set_valid |=>
      $stable(ms_ff) && $stable(day_ff) && $stable(month_ff) && $stable(year_ff))
      else $error("rejected set changed the calendar");

endmodule
`default_nettype wire

// File: hw/rtl/ccmt_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccmt_out_stage - result register of the calendar clock
//
// Holds one result until the response transfer completes and packs it.
// ----------------------------------------------------------------------------
module ccmt_out_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step_en,
   input  wire ccmt_pkg::ccmt_rsp_type rsp,
   output logic                        take,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [79:0]                 rsp_tdata,
   output logic                        rsp_tuser
);
   import ccmt_pkg::*;

   logic         rsp_vld_ff;
   logic         rsp_vld_in;
   ccmt_rsp_type rsp_ff;

   // Room for a new result when empty or when the held one leaves now.
   assign take = !rsp_vld_ff || rsp_tready;

   assign rsp_vld_in = take ? step_en : rsp_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_ff <= rsp;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_ff.set_ok;
   assign rsp_tdata  = {rsp_ff.uptime_ms, rsp_ff.cur_year, rsp_ff.cur_month,
                        rsp_ff.cur_day, rsp_ff.cur_hour, rsp_ff.cur_min,
                        rsp_ff.cur_sec, rsp_ff.cur_msec};

endmodule
`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - calendar clock stream testbench
//
// Sends tick and set transfers into the calendar clock and checks every
// response against a cycle-free calendar predictor kept in the bench.
// Directed cases cover field limits, month and leap-day carries and rejected
// loads; random traffic mixes near-boundary loads, tick runs and malformed
// loads under varying idle patterns, plus one long response stall.
// ----------------------------------------------------------------------------
module tb;
   import ccmt_pkg::*;

   localparam int STALL_CYCLES   = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // new_msec, new_sec, new_min, new_hour, new_day, new_month, new_year
   logic [47:0] req_tdata = '0;
   // cmd
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // cur_msec, cur_sec, cur_min, cur_hour, cur_day, cur_month, cur_year, uptime_ms
   logic [79:0] rsp_tdata;
   // set_ok
   logic        rsp_tuser;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_request = 0;
   int items_sent    = 0;
   int error_count   = 0;

   ccmt_rsp_type pending_times[$];

   // Predicted calendar state
   logic [9:0]  cal_msec     = '0;
   logic [5:0]  cal_sec      = '0;
   logic [5:0]  cal_min      = '0;
   logic [4:0]  cal_hour     = '0;
   logic [4:0]  cal_day      = DAY_FIRST;
   logic [3:0]  cal_month    = MONTH_FIRST;
   logic [6:0]  cal_year_off = '0;
   logic [31:0] cal_uptime   = '0;

   calendar_clock_ms_tick u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [4:0] days_of_month(input logic [3:0] month,
                                                input logic [1:0] year_low);
      return MONTH_LEN[month] + ((month == MONTH_FEB && year_low == 2'd0) ? 5'd1 : 5'd0);
   endfunction

   // Apply one item to the predicted calendar and return the response it causes.
   function automatic ccmt_rsp_type calendar_step(input ccmt_item_type it);
      ccmt_rsp_type r;
      logic carry;
      logic loaded;
      loaded = 1'b0;
      if (it.cmd == CMD_TICK) begin
         cal_uptime = cal_uptime + 32'd1;
         carry = 1'b1;
         if (cal_msec < MSEC_MAX) begin
            cal_msec = cal_msec + 10'd1;
            carry = 1'b0;
         end else begin
            cal_msec = '0;
         end
         if (carry) begin
            if (cal_sec < SEC_MAX) begin
               cal_sec = cal_sec + 6'd1;
               carry = 1'b0;
            end else begin
               cal_sec = '0;
            end
         end
         if (carry) begin
            if (cal_min < MIN_MAX) begin
               cal_min = cal_min + 6'd1;
               carry = 1'b0;
            end else begin
               cal_min = '0;
            end
         end
         if (carry) begin
            if (cal_hour < HOUR_MAX) begin
               cal_hour = cal_hour + 5'd1;
               carry = 1'b0;
            end else begin
               cal_hour = '0;
            end
         end
         if (carry) begin
            if (cal_day < days_of_month(cal_month, cal_year_off[1:0])) begin
               cal_day = cal_day + 5'd1;
               carry = 1'b0;
            end else begin
               cal_day = DAY_FIRST;
            end
         end
         if (carry) begin
            if (cal_month < MONTH_MAX) begin
               cal_month = cal_month + 4'd1;
               carry = 1'b0;
            end else begin
               cal_month = MONTH_FIRST;
            end
         end
         if (carry) begin
            cal_year_off = cal_year_off + 7'd1;
         end
      end else if (it.new_msec <= MSEC_MAX && it.new_sec <= SEC_MAX
                   && it.new_min <= MIN_MAX && it.new_hour <= HOUR_MAX
                   && it.new_day >= DAY_FIRST && it.new_month >= MONTH_FIRST
                   && it.new_month <= MONTH_MAX && it.new_year >= YEAR_BASE
                   && it.new_year <= YEAR_LAST
                   && it.new_day <= days_of_month(it.new_month, it.new_year[1:0])) begin
         cal_msec     = it.new_msec;
         cal_sec      = it.new_sec;
         cal_min      = it.new_min;
         cal_hour     = it.new_hour;
         cal_day      = it.new_day;
         cal_month    = it.new_month;
         cal_year_off = 7'(it.new_year - YEAR_BASE);
         loaded = 1'b1;
      end
      r.cur_msec  = cal_msec;
      r.cur_sec   = cal_sec;
      r.cur_min   = cal_min;
      r.cur_hour  = cal_hour;
      r.cur_day   = cal_day;
      r.cur_month = cal_month;
      r.cur_year  = YEAR_BASE + {5'd0, cal_year_off};
      r.set_ok    = loaded;
      r.uptime_ms = cal_uptime;
      return r;
   endfunction

   function automatic ccmt_item_type set_item(input int ms, input int sec, input int mn,
                                              input int hr, input int dy, input int mo,
                                              input int yr);
      ccmt_item_type it;
      it.cmd       = CMD_SET;
      it.new_msec  = ms[9:0];
      it.new_sec   = sec[5:0];
      it.new_min   = mn[5:0];
      it.new_hour  = hr[4:0];
      it.new_day   = dy[4:0];
      it.new_month = mo[3:0];
      it.new_year  = yr[11:0];
      return it;
   endfunction

   function automatic ccmt_item_type tick_item(input logic [47:0] filler);
      ccmt_item_type it;
      it = ccmt_item_type'({1'b0, filler});
      it.cmd = CMD_TICK;
      return it;
   endfunction

   // Valid load that sits close to a carry boundary most of the time.
   function automatic ccmt_item_type boundary_set_item();
      int yr;
      int mo;
      int len;
      int dy;
      yr  = $urandom_range(YEAR_LAST, YEAR_BASE);
      mo  = $urandom_range(MONTH_MAX, MONTH_FIRST);
      len = int'(days_of_month(mo[3:0], yr[1:0]));
      dy  = ($urandom_range(99) < 70) ? len - $urandom_range(1, 0) : $urandom_range(len, 1);
      return set_item(($urandom_range(99) < 70) ? MSEC_MAX - $urandom_range(9, 0)
                                                : $urandom_range(MSEC_MAX, 0),
                      ($urandom_range(99) < 70) ? SEC_MAX : $urandom_range(SEC_MAX, 0),
                      ($urandom_range(99) < 70) ? MIN_MAX : $urandom_range(MIN_MAX, 0),
                      ($urandom_range(99) < 70) ? HOUR_MAX : $urandom_range(HOUR_MAX, 0),
                      dy, mo, yr);
   endfunction

   task automatic send_calendar_item(input ccmt_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {it.new_year, it.new_month, it.new_day, it.new_hour,
                     it.new_min, it.new_sec, it.new_msec};
      req_tuser  <= it.cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_times.push_back(calendar_step(it));
      items_sent++;
   endtask

   task automatic run_random_items(input int count);
      int stop_at;
      int pick;
      logic [63:0] raw;
      ccmt_item_type it;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         raw  = {$urandom, $urandom};
         if (pick < 60) begin
            // load near a boundary, then tick across it
            send_calendar_item(boundary_set_item());
            repeat ($urandom_range(12, 1)) begin
               raw = {$urandom, $urandom};
               send_calendar_item(tick_item(raw[47:0]));
            end
         end else if (pick < 75) begin
            it = ccmt_item_type'(raw[48:0]);
            it.cmd = CMD_SET;
            send_calendar_item(it);
         end else if (pick < 90) begin
            // valid load with one field pushed out of range
            it = boundary_set_item();
            case ($urandom_range(6))
               0: it.new_msec = 10'($urandom_range(1023, MSEC_MAX + 1));
               1: it.new_sec  = 6'($urandom_range(63, SEC_MAX + 1));
               2: it.new_min  = 6'($urandom_range(63, MIN_MAX + 1));
               3: it.new_hour = 5'($urandom_range(31, HOUR_MAX + 1));
               4: it.new_day  = (days_of_month(it.new_month, it.new_year[1:0]) == 5'd31
                                 || $urandom_range(1)) ? 5'd0
                              : 5'($urandom_range(31, days_of_month(it.new_month,
                                                                    it.new_year[1:0]) + 1));
               5: it.new_month = $urandom_range(1) ? 4'd0
                                                   : 4'($urandom_range(15, MONTH_MAX + 1));
               default: it.new_year = $urandom_range(1)
                                      ? 12'($urandom_range(YEAR_BASE - 1, 0))
                                      : 12'($urandom_range(4095, YEAR_LAST + 1));
            endcase
            send_calendar_item(it);
         end else begin
            repeat ($urandom_range(20, 1)) begin
               raw = {$urandom, $urandom};
               send_calendar_item(tick_item(raw[47:0]));
            end
         end
      end
   endtask

   task automatic test_tick_from_reset();
      send_calendar_item(tick_item('0));
   endtask

   task automatic test_valid_set_limits();
      send_calendar_item(set_item(0, 0, 0, 0, 1, 1, 2000));
      send_calendar_item(set_item(999, 59, 59, 23, 31, 12, 2099));
      send_calendar_item(tick_item('0));
      send_calendar_item(set_item(999, 59, 59, 23, 29, 2, 2024));
      send_calendar_item(tick_item('0));
      send_calendar_item(set_item(999, 59, 59, 23, 28, 2, 2023));
      send_calendar_item(tick_item('0));
      send_calendar_item(set_item(999, 59, 59, 23, 28, 2, 2024));
      send_calendar_item(tick_item('0));
      send_calendar_item(set_item(999, 59, 59, 23, 30, 4, 2023));
      send_calendar_item(tick_item('0));
   endtask

   task automatic test_rejected_sets();
      send_calendar_item(set_item(1023, 0, 0, 0, 1, 1, 2000));
      send_calendar_item(set_item(0, 63, 0, 0, 1, 1, 2000));
      send_calendar_item(set_item(0, 0, 63, 0, 1, 1, 2000));
      send_calendar_item(set_item(0, 0, 0, 31, 1, 1, 2000));
      send_calendar_item(set_item(0, 0, 0, 0, 0, 1, 2000));
      send_calendar_item(set_item(0, 0, 0, 0, 1, 0, 2000));
      send_calendar_item(set_item(0, 0, 0, 0, 1, 13, 2000));
      send_calendar_item(set_item(0, 0, 0, 0, 1, 15, 2000));
      send_calendar_item(set_item(0, 0, 0, 0, 1, 1, 1999));
      send_calendar_item(set_item(0, 0, 0, 0, 1, 1, 2100));
      send_calendar_item(set_item(0, 0, 0, 0, 1, 1, 4095));
      send_calendar_item(set_item(0, 0, 0, 0, 29, 2, 2023));
      send_calendar_item(set_item(0, 0, 0, 0, 31, 4, 2024));
   endtask

   task automatic test_random_traffic();
      send_idle_pct = 17;
      recv_idle_pct = 63;
      run_random_items(600);
      send_idle_pct = 63;
      recv_idle_pct = 17;
      run_random_items(600);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_items(600);
   endtask

   task automatic test_output_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_request <= stall_request + 1;
      run_random_items(40);
   endtask

   // Response side ready pattern, with a long hold on request
   initial begin : rsp_ready_gen
      int stall_left;
      int stall_seen;
      stall_left = 0;
      stall_seen = 0;
      forever begin
         @(posedge clock);
         if (stall_request != stall_seen) begin
            stall_seen = stall_request;
            stall_left = STALL_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      ccmt_rsp_type got;
      ccmt_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.cur_msec  = rsp_tdata[9:0];
         got.cur_sec   = rsp_tdata[15:10];
         got.cur_min   = rsp_tdata[21:16];
         got.cur_hour  = rsp_tdata[26:22];
         got.cur_day   = rsp_tdata[31:27];
         got.cur_month = rsp_tdata[35:32];
         got.cur_year  = rsp_tdata[47:36];
         got.uptime_ms = rsp_tdata[79:48];
         got.set_ok    = rsp_tuser;
         if (pending_times.size() == 0) begin
            $display("%0t: unexpected transfer: expected none, actual data %h set_ok %b",
                     $time, rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            want = pending_times.pop_front();
            compare_field("cur_msec", want.cur_msec, got.cur_msec);
            compare_field("cur_sec", want.cur_sec, got.cur_sec);
            compare_field("cur_min", want.cur_min, got.cur_min);
            compare_field("cur_hour", want.cur_hour, got.cur_hour);
            compare_field("cur_day", want.cur_day, got.cur_day);
            compare_field("cur_month", want.cur_month, got.cur_month);
            compare_field("cur_year", want.cur_year, got.cur_year);
            compare_field("set_ok", want.set_ok, got.set_ok);
            compare_field("uptime_ms", want.uptime_ms, got.uptime_ms);
         end
      end
   end

   // Abort when no transfer happens on either side for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      send_idle_pct = 17;
      recv_idle_pct = 63;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_tick_from_reset();
      test_valid_set_limits();
      test_rejected_sets();
      test_random_traffic();
      test_output_backpressure();
      req_tvalid <= 1'b0;
      while (pending_times.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
